// File: hw/rtl/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned ProdW   = 26;
  localparam int unsigned FracW   = 16;
  localparam int unsigned SumW    = ProdW - FracW;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic signed [ProdW-1:0] CrToR = 26'sd91881;
  localparam logic signed [ProdW-1:0] CbToB = 26'sd116130;
  localparam logic signed [ProdW-1:0] CbToG = 26'sd22554;
  localparam logic signed [ProdW-1:0] CrToG = 26'sd46802;

  localparam logic [AddrW-1:0] RegOrder = 3'd0;

  typedef logic [Lanes-1:0][ChanW-1:0] luma_t;

  typedef struct packed {
    logic signed [ChanW-1:0] r;
    logic signed [ChanW-1:0] g;
    logic signed [ChanW-1:0] b;
  } chroma_off_t;

  function automatic logic signed [ChanW-1:0] clamp_off(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] lo;
    logic signed [SumW-1:0] hi;
    lo = -(SumW'(128));
    hi = SumW'(127);
    if (x < lo) begin
      clamp_off = -8'sd128;
    end else if (x > hi) begin
      clamp_off = 8'sd127;
    end else begin
      clamp_off = x[ChanW-1:0];
    end
  endfunction

  function automatic logic [ChanW-1:0] sat_chan(input logic [ChanW-1:0] luma,
                                               input logic signed [ChanW-1:0] off);
    logic signed [ChanW+1:0] s;
    s = $signed({2'b00, luma}) + {{2{off[ChanW-1]}}, off};
    if (s < 0) begin
      sat_chan = '0;
    end else if (s > 10'sd255) begin
      sat_chan = '1;
    end else begin
      sat_chan = s[ChanW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/yuvrgb_chroma.sv
`default_nettype none

module yuvrgb_chroma
  import yuvrgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output      logic              ready_o,
  input  wire logic [ChanW-1:0]  chroma_u_i,
  input  wire logic [ChanW-1:0]  chroma_v_i,
  input  wire luma_t             luma_i,
  output      logic              valid_o,
  input  wire logic              ready_i,
  output      chroma_off_t       off_o,
  output      luma_t             luma_o
);

  logic                      prod_v_q;
  logic signed [ProdW-1:0]   prod_r_q, prod_b_q, prod_gu_q, prod_gv_q;
  luma_t                     prod_luma_q;
  logic                      off_v_q;
  chroma_off_t               off_q;
  luma_t                     off_luma_q;

  logic signed [ChanW-1:0]   cu, cv;
  logic signed [ProdW-1:0]   cu_x, cv_x;
  logic signed [ProdW-1:0]   green_sum;
  logic                      off_ready, prod_ready;

  assign cu   = $signed({~chroma_u_i[ChanW-1], chroma_u_i[ChanW-2:0]});
  assign cv   = $signed({~chroma_v_i[ChanW-1], chroma_v_i[ChanW-2:0]});
  assign cu_x = {{(ProdW-ChanW){cu[ChanW-1]}}, cu};
  assign cv_x = {{(ProdW-ChanW){cv[ChanW-1]}}, cv};

  assign off_ready  = !off_v_q || ready_i;
  assign prod_ready = !prod_v_q || off_ready;
  assign ready_o    = prod_ready;

  assign green_sum = -prod_gu_q - prod_gv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      off_v_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_v_q <= valid_i;
      end
      if (off_ready) begin
        off_v_q <= prod_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_ready && valid_i) begin
      prod_r_q    <= cv_x * CrToR;
      prod_b_q    <= cu_x * CbToB;
      prod_gu_q   <= cu_x * CbToG;
      prod_gv_q   <= cv_x * CrToG;
      prod_luma_q <= luma_i;
    end
    if (off_ready && prod_v_q) begin
      off_q.r    <= clamp_off(prod_r_q[ProdW-1:FracW]);
      off_q.b    <= clamp_off(prod_b_q[ProdW-1:FracW]);
      off_q.g    <= clamp_off(green_sum[ProdW-1:FracW]);
      off_luma_q <= prod_luma_q;
    end
  end

  assign valid_o = off_v_q;
  assign off_o   = off_q;
  assign luma_o  = off_luma_q;

endmodule

`default_nettype wire

// File: hw/rtl/yuvrgb_lane.sv
`default_nettype none

module yuvrgb_lane
  import yuvrgb_pkg::*;
(
  input  wire logic [ChanW-1:0] luma_i,
  input  wire chroma_off_t      off_i,
  input  wire logic             red_low_i,
  output      logic [PixW-1:0]  pixel_o
);

  logic [ChanW-1:0] r, g, b;

  assign r = sat_chan(luma_i, off_i.r);
  assign g = sat_chan(luma_i, off_i.g);
  assign b = sat_chan(luma_i, off_i.b);

  assign pixel_o = red_low_i ? {b, g, r} : {r, g, b};

endmodule

`default_nettype wire

// File: hw/rtl/yuv420_block_to_rgb.sv
`default_nettype none

// Channel   Direction  Handshake                       Payload
// block     in         block_valid_i / block_stall_o   chroma_u_i, chroma_v_i, luma_*_i
// pixel     out        pixel_valid_o / pixel_stall_i   pixel_*_o
// config    in         APB (psel, penable, pwrite)     paddr, pwdata, prdata
//
// One block per cycle while the output is not stalled; an accepted block passes
// the product, offset and lane output registers in turn before it is output.
// Reset clears all valid flags and sets the byte order to red in the low byte.
// A stall on the output holds only the stages behind an occupied register;
// empty stages keep filling, so block_stall_o rises only when all stages are full.

module yuv420_block_to_rgb
  import yuvrgb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              block_valid_i,
  output      logic              block_stall_o,
  input  wire logic [ChanW-1:0]  chroma_u_i,
  input  wire logic [ChanW-1:0]  chroma_v_i,
  input  wire logic [ChanW-1:0]  luma_top_left_i,
  input  wire logic [ChanW-1:0]  luma_top_right_i,
  input  wire logic [ChanW-1:0]  luma_bottom_left_i,
  input  wire logic [ChanW-1:0]  luma_bottom_right_i,
  output      logic              pixel_valid_o,
  input  wire logic              pixel_stall_i,
  output      logic [PixW-1:0]   pixel_top_left_o,
  output      logic [PixW-1:0]   pixel_top_right_o,
  output      logic [PixW-1:0]   pixel_bottom_left_o,
  output      logic [PixW-1:0]   pixel_bottom_right_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output      logic [DataW-1:0]  prdata,
  output      logic              pready
);

  logic                          red_low_q;
  logic                          in_ready;
  logic                          off_valid;
  logic                          out_ready;
  chroma_off_t                   off;
  luma_t                         luma_in, luma_off;
  logic [Lanes-1:0][PixW-1:0]    lane_pix;
  logic [Lanes-1:0][PixW-1:0]    pix_q;
  logic                          pix_v_q;
  logic                          reg_hit;

  assign reg_hit = (paddr & ~AddrW'(3)) == RegOrder;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(DataW-1){1'b0}}, red_low_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_low_q <= 1'b1;
    end else if (psel && penable && pwrite && reg_hit) begin
      red_low_q <= pwdata[0];
    end
  end

  assign luma_in = {luma_bottom_right_i, luma_bottom_left_i,
                    luma_top_right_i, luma_top_left_i};

  yuvrgb_chroma u_chroma (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (block_valid_i),
    .ready_o    (in_ready),
    .chroma_u_i (chroma_u_i),
    .chroma_v_i (chroma_v_i),
    .luma_i     (luma_in),
    .valid_o    (off_valid),
    .ready_i    (out_ready),
    .off_o      (off),
    .luma_o     (luma_off)
  );

  assign block_stall_o = !in_ready;

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    yuvrgb_lane u_lane (
      .luma_i    (luma_off[i]),
      .off_i     (off),
      .red_low_i (red_low_q),
      .pixel_o   (lane_pix[i])
    );
  end

  assign out_ready = !pix_v_q || !pixel_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_v_q <= 1'b0;
    end else if (out_ready) begin
      pix_v_q <= off_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && off_valid) begin
      pix_q <= lane_pix;
    end
  end

  assign pixel_valid_o        = pix_v_q;
  assign pixel_top_left_o     = pix_q[0];
  assign pixel_top_right_o    = pix_q[1];
  assign pixel_bottom_left_o  = pix_q[2];
  assign pixel_bottom_right_o = pix_q[3];

endmodule

`default_nettype wire
